// ----- design/classifier_metric_accumulator_top_macros.svh -----
// assertion macros shared by the classifier metric accumulator rtl
// no dependencies; included by files that carry concurrent checks
`ifndef CLASSIFIER_METRIC_ACCUMULATOR_TOP_MACROS_SVH
`define CLASSIFIER_METRIC_ACCUMULATOR_TOP_MACROS_SVH
`ifndef ASSERT_OFF
`define CMA_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("implication check failed");
`define CMA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("next-cycle check failed");
`else
`define CMA_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define CMA_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- design/cma_pkg.sv -----
// constants, types and helpers for the classifier metric accumulator
// no dependencies; used by every module of the block
package cma_pkg;
	localparam int NUM_CLASSES = 16;
	localparam int CB          = 32;
	localparam int MAX_OUT     = 16;
	localparam int NUM_OUT     = (NUM_CLASSES > MAX_OUT) ? MAX_OUT : NUM_CLASSES;
	localparam int CLS_W       = $clog2(NUM_CLASSES);
	localparam int Q_W         = 17;
	localparam int FRAC_W      = 16;
	localparam int SUM_W       = CB + CLS_W;
	localparam int F1S_W       = Q_W + CLS_W;
	localparam int NV_W        = CLS_W + 1;
	localparam int DEN_W       = SUM_W;
	localparam int NUM_W       = (SUM_W > F1S_W) ? SUM_W : F1S_W;
	localparam int STEP_W      = $clog2(NUM_W + 1);

	typedef struct packed {
		logic             upd_rd;
		logic             wr;
		logic             in_range;
		logic [CLS_W-1:0] pred_idx;
		logic [CLS_W-1:0] act_idx;
		logic [CLS_W-1:0] cls_idx;
	} cnt_ctrl_t;

	typedef struct packed {
		logic             start;
		logic             int_mode;
		logic [NUM_W-1:0] num;
		logic [DEN_W-1:0] den;
	} div_req_t;

	function automatic logic [CB-1:0] sat_inc(input logic [CB-1:0] v);
		return (&v) ? v : v + CB'(1);
	endfunction
endpackage

// ----- design/cma_counters.sv -----
// per-class predicted, correct and occurrence counters with saturating update
// depends on cma_pkg
module cma_counters (
	input  logic                    clk,
	input  logic                    arst_n,
	input  cma_pkg::cnt_ctrl_t      ctrl,
	output logic [cma_pkg::CB-1:0]  pred_cnt,
	output logic [cma_pkg::CB-1:0]  corr_cnt,
	output logic [cma_pkg::CB-1:0]  occ_cnt
);
	import cma_pkg::*;

	logic [CB-1:0]          pred_mem [NUM_CLASSES];
	logic [CB-1:0]          corr_mem [NUM_CLASSES];
	logic [CB-1:0]          occ_mem  [NUM_CLASSES];
	logic [NUM_CLASSES-1:0] pv_q, cv_q, ov_q;
	logic [CB-1:0]          pred_rd_q, corr_rd_q, occ_rd_q;
	logic [CLS_W-1:0]       rd_p, rd_a;
	logic                   wr_en, same;

	assign rd_p  = ctrl.upd_rd ? ctrl.pred_idx : ctrl.cls_idx;
	assign rd_a  = ctrl.upd_rd ? ctrl.act_idx : ctrl.cls_idx;
	assign wr_en = ctrl.wr && ctrl.in_range;
	assign same  = ctrl.pred_idx == ctrl.act_idx;

	// entry valid bits stand in for clearing the arrays
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pv_q <= '0;
			cv_q <= '0;
			ov_q <= '0;
		end else if (wr_en) begin
			pv_q[ctrl.pred_idx] <= 1'b1;
			ov_q[ctrl.act_idx]  <= 1'b1;
			if (same) begin
				cv_q[ctrl.pred_idx] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		pred_rd_q <= pv_q[rd_p] ? pred_mem[rd_p] : '0;
		corr_rd_q <= cv_q[rd_p] ? corr_mem[rd_p] : '0;
		occ_rd_q  <= ov_q[rd_a] ? occ_mem[rd_a] : '0;
		if (wr_en) begin
			pred_mem[ctrl.pred_idx] <= sat_inc(pred_rd_q);
			occ_mem[ctrl.act_idx]   <= sat_inc(occ_rd_q);
			if (same) begin
				corr_mem[ctrl.pred_idx] <= sat_inc(corr_rd_q);
			end
		end
	end

	assign pred_cnt = pred_rd_q;
	assign corr_cnt = corr_rd_q;
	assign occ_cnt  = occ_rd_q;
endmodule

// ----- design/cma_serial_div.sv -----
// bit-serial restoring divider, one quotient bit per cycle
// depends on cma_pkg; ratio mode gives num*2^16/den for num <= den
module cma_serial_div (
	input  logic                   clk,
	input  logic                   arst_n,
	input  cma_pkg::div_req_t      req,
	output logic                   busy,
	output logic                   done,
	output logic [cma_pkg::Q_W-1:0] quo
);
	import cma_pkg::*;

	logic               busy_q, done_q, first_q;
	logic [STEP_W-1:0]  cnt_q;
	logic [DEN_W:0]     rem_q, sh, diff;
	logic [NUM_W-1:0]   dvd_q;
	logic [DEN_W-1:0]   den_q;
	logic [Q_W-1:0]     quo_q;
	logic               ge;

	assign sh   = first_q ? rem_q : {rem_q[DEN_W-1:0], dvd_q[NUM_W-1]};
	assign diff = sh - {1'b0, den_q};
	assign ge   = sh >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= req.int_mode ? STEP_W'(NUM_W) : STEP_W'(Q_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - STEP_W'(1);
				if (cnt_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			first_q <= !req.int_mode;
			rem_q   <= req.int_mode ? '0 : {1'b0, req.num[DEN_W-1:0]};
			dvd_q   <= req.int_mode ? req.num : '0;
			den_q   <= req.den;
			quo_q   <= '0;
		end else if (busy_q) begin
			first_q <= 1'b0;
			rem_q   <= ge ? diff : sh;
			dvd_q   <= {dvd_q[NUM_W-2:0], 1'b0};
			quo_q   <= {quo_q[Q_W-2:0], ge};
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign quo  = quo_q;
endmodule

// ----- design/classifier_metric_accumulator_top.sv -----
// top level of the classifier metric accumulator: sequencer, f1 store, output register
// depends on cma_pkg, cma_counters, cma_serial_div and the assertion macro header
//
// Each transfer on the s_ side carries one (predicted, actual) class pair. The block
// bumps three saturating per-class counters (predictions, correct predictions, true
// occurrences), then sends sixteen result transfers on the m_ side, class 0 first,
// with tlast on the last one. Every result holds that class's precision, recall and
// F1, plus the overall accuracy and the macro F1, all unsigned Q1.16 truncated; a
// ratio with a zero denominator (or an F1 with zero correct) reads as 0 with its ok
// flag low (accuracy has no flag). All divisions share one bit-serial divider that
// yields one quotient bit per clock while busy; a quotient is taken on its done flag.
// An item runs the counter update (read, then write), then for every class an F1
// division (skipped when its correct count is zero), then the accuracy and the
// macro average divisions, and then for every result a precision and a recall
// division (each skipped on a zero count) before the result is loaded into the
// output register, where it waits while the m_ side stalls. s_tready is high only
// while the sequencer is idle, so one pair is worked on at a time; the last result
// may still wait in the output register while the next pair is taken. Counters
// clear asynchronously on arst_n; there is no clearing pass.
module classifier_metric_accumulator_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,  // predicted_class[3:0], actual_class[7:4]
	output logic        m_tvalid,
	input  logic        m_tready,
	// class_index[3:0], precision_q[20:4], precision_ok[21], recall_q[38:22],
	// recall_ok[39], f1_q[56:40], f1_ok[57], accuracy_q[74:58], macro_f1_q[91:75],
	// macro_f1_ok[92], zero fill[95:93]
	output logic [95:0] m_tdata,
	output logic        m_tlast   // last_class
);
	import cma_pkg::*;
	`include "classifier_metric_accumulator_top_macros.svh"

	// sequencer states
	localparam logic [4:0] ST_IDLE      = 5'd0;
	localparam logic [4:0] ST_UPD_RD    = 5'd1;
	localparam logic [4:0] ST_UPD_WR    = 5'd2;
	localparam logic [4:0] ST_F_RD      = 5'd3;
	localparam logic [4:0] ST_F_START   = 5'd4;
	localparam logic [4:0] ST_F_WAIT    = 5'd5;
	localparam logic [4:0] ST_F_NEXT    = 5'd6;
	localparam logic [4:0] ST_ACC_START = 5'd7;
	localparam logic [4:0] ST_ACC_WAIT  = 5'd8;
	localparam logic [4:0] ST_MAC_START = 5'd9;
	localparam logic [4:0] ST_MAC_WAIT  = 5'd10;
	localparam logic [4:0] ST_E_RD      = 5'd11;
	localparam logic [4:0] ST_P_START   = 5'd12;
	localparam logic [4:0] ST_P_WAIT    = 5'd13;
	localparam logic [4:0] ST_R_START   = 5'd14;
	localparam logic [4:0] ST_R_WAIT    = 5'd15;
	localparam logic [4:0] ST_OUT       = 5'd16;

	logic [4:0]             state_q, state_d;
	logic [3:0]             pred_q, act_q;
	logic [CLS_W-1:0]       cls_q;
	logic [SUM_W-1:0]       sum_c_q, sum_t_q;
	logic [F1S_W-1:0]       sum_f1_q;
	logic [NV_W-1:0]        nvalid_q;
	logic [Q_W-1:0]         acc_q, mf1_q, prec_q, rec_q;
	logic [Q_W-1:0]         f1_mem [NUM_CLASSES];
	logic [Q_W-1:0]         f1_rd_q;
	logic [NUM_CLASSES-1:0] f1ok_q;

	logic [CB-1:0]          pc, cc, tc;
	cnt_ctrl_t              cnt_ctrl;
	div_req_t               div_req;
	logic                   div_busy, div_done;
	logic [Q_W-1:0]         div_quo;

	logic                   m_tvalid_q;
	logic [95:0]            m_tdata_q;
	logic                   m_tlast_q;
	logic                   out_free, last_cls, cls_last_all;
	logic [CB:0]            f1_den, f1_num;

	assign s_tready     = state_q == ST_IDLE;
	assign out_free     = !m_tvalid_q || m_tready;
	assign last_cls     = cls_q == CLS_W'(NUM_OUT - 1);
	assign cls_last_all = cls_q == CLS_W'(NUM_CLASSES - 1);
	assign f1_den       = {1'b0, pc} + {1'b0, tc};
	assign f1_num       = {cc, 1'b0};

	// counter bank: update addresses only during the read half of the update
	always_comb begin
		cnt_ctrl.upd_rd   = state_q == ST_UPD_RD;
		cnt_ctrl.wr       = state_q == ST_UPD_WR;
		cnt_ctrl.in_range = (32'(pred_q) < NUM_CLASSES) && (32'(act_q) < NUM_CLASSES);
		cnt_ctrl.pred_idx = CLS_W'(pred_q);
		cnt_ctrl.act_idx  = CLS_W'(act_q);
		cnt_ctrl.cls_idx  = cls_q;
	end

	cma_counters u_counters (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (cnt_ctrl),
		.pred_cnt (pc),
		.corr_cnt (cc),
		.occ_cnt  (tc)
	);

	// divider requests; num never exceeds den in ratio mode
	always_comb begin
		div_req = '0;
		case (state_q)
			ST_F_START: begin
				div_req.start = cc != '0;
				div_req.num   = NUM_W'(f1_num);
				div_req.den   = DEN_W'(f1_den);
			end
			ST_ACC_START: begin
				div_req.start = sum_t_q != '0;
				div_req.num   = NUM_W'(sum_c_q);
				div_req.den   = DEN_W'(sum_t_q);
			end
			ST_MAC_START: begin
				div_req.start    = nvalid_q != '0;
				div_req.int_mode = 1'b1;
				div_req.num      = NUM_W'(sum_f1_q);
				div_req.den      = DEN_W'(nvalid_q);
			end
			ST_P_START: begin
				div_req.start = pc != '0;
				div_req.num   = NUM_W'(cc);
				div_req.den   = DEN_W'(pc);
			end
			ST_R_START: begin
				div_req.start = tc != '0;
				div_req.num   = NUM_W'(cc);
				div_req.den   = DEN_W'(tc);
			end
			default: begin
				div_req = '0;
			end
		endcase
	end

	cma_serial_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.busy   (div_busy),
		.done   (div_done),
		.quo    (div_quo)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:      if (s_tvalid) state_d = ST_UPD_RD;
			ST_UPD_RD:    state_d = ST_UPD_WR;
			ST_UPD_WR:    state_d = ST_F_RD;
			ST_F_RD:      state_d = ST_F_START;
			ST_F_START:   state_d = (cc != '0) ? ST_F_WAIT : ST_F_NEXT;
			ST_F_WAIT:    if (div_done) state_d = ST_F_NEXT;
			ST_F_NEXT:    state_d = cls_last_all ? ST_ACC_START : ST_F_RD;
			ST_ACC_START: state_d = (sum_t_q != '0) ? ST_ACC_WAIT : ST_MAC_START;
			ST_ACC_WAIT:  if (div_done) state_d = ST_MAC_START;
			ST_MAC_START: state_d = (nvalid_q != '0) ? ST_MAC_WAIT : ST_E_RD;
			ST_MAC_WAIT:  if (div_done) state_d = ST_E_RD;
			ST_E_RD:      state_d = ST_P_START;
			ST_P_START:   state_d = (pc != '0) ? ST_P_WAIT : ST_R_START;
			ST_P_WAIT:    if (div_done) state_d = ST_R_START;
			ST_R_START:   state_d = (tc != '0) ? ST_R_WAIT : ST_OUT;
			ST_R_WAIT:    if (div_done) state_d = ST_OUT;
			ST_OUT:       if (out_free) state_d = last_cls ? ST_IDLE : ST_E_RD;
			default:      state_d = ST_IDLE;
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			cls_q      <= '0;
			m_tvalid_q <= 1'b0;
			f1ok_q     <= '0;
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_UPD_WR:    cls_q <= '0;
				ST_F_START:   f1ok_q[cls_q] <= cc != '0;
				ST_F_NEXT:    if (!cls_last_all) cls_q <= cls_q + CLS_W'(1);
				ST_MAC_START: if (nvalid_q == '0) cls_q <= '0;
				ST_MAC_WAIT:  if (div_done) cls_q <= '0;
				ST_OUT:       if (out_free && !last_cls) cls_q <= cls_q + CLS_W'(1);
				default:      cls_q <= cls_q;
			endcase
			// output register: a waiting result is held until its transfer
			if (state_q == ST_OUT && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		f1_rd_q <= f1_mem[cls_q];
		case (state_q)
			ST_IDLE: begin
				pred_q <= s_tdata[3:0];
				act_q  <= s_tdata[7:4];
			end
			ST_UPD_WR: begin
				sum_c_q  <= '0;
				sum_t_q  <= '0;
				sum_f1_q <= '0;
				nvalid_q <= '0;
			end
			ST_F_START: begin
				sum_c_q <= sum_c_q + SUM_W'(cc);
				sum_t_q <= sum_t_q + SUM_W'(tc);
			end
			ST_F_WAIT: begin
				if (div_done) begin
					f1_mem[cls_q] <= div_quo;
					sum_f1_q      <= sum_f1_q + F1S_W'(div_quo);
					nvalid_q      <= nvalid_q + NV_W'(1);
				end
			end
			ST_ACC_START: acc_q <= '0;
			ST_ACC_WAIT:  if (div_done) acc_q <= div_quo;
			ST_MAC_START: mf1_q <= '0;
			ST_MAC_WAIT:  if (div_done) mf1_q <= div_quo;
			ST_P_START:   prec_q <= '0;
			ST_P_WAIT:    if (div_done) prec_q <= div_quo;
			ST_R_START:   rec_q <= '0;
			ST_R_WAIT:    if (div_done) rec_q <= div_quo;
			ST_OUT: begin
				if (out_free) begin
					m_tdata_q <= {3'b000, nvalid_q != '0, mf1_q, acc_q,
						f1ok_q[cls_q], f1ok_q[cls_q] ? f1_rd_q : Q_W'(0),
						tc != '0, rec_q, pc != '0, prec_q, 4'(cls_q)};
					m_tlast_q <= last_cls;
				end
			end
			default: begin
				pred_q <= pred_q;
			end
		endcase
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;

	// a new division is only requested while the divider is free
	`CMA_ASSERT_IMPLY(a_div_free, clk, arst_n, div_req.start, !div_busy)
	// a finished quotient only arrives while the sequencer waits for it
	`CMA_ASSERT_IMPLY(a_done_wait, clk, arst_n, div_done,
		state_q == ST_F_WAIT || state_q == ST_ACC_WAIT || state_q == ST_MAC_WAIT ||
		state_q == ST_P_WAIT || state_q == ST_R_WAIT)
	// the divider is never left running once the sequencer is back to idle
	`CMA_ASSERT_IMPLY(a_idle_quiet, clk, arst_n, state_q == ST_IDLE, !div_busy)
	// taking a pair always starts the counter update
	`CMA_ASSERT_NEXT(a_accept_upd, clk, arst_n, s_tvalid && s_tready, state_q == ST_UPD_RD)
endmodule
